FILE: hw/rtl/pnz_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the permutation ROM for the 2-D gradient noise block.
// No dependencies; every other file imports this package.

package pnz_pkg;

  localparam int COORD_W        = 32;
  localparam int NOISE_W        = 16;
  localparam int CELL_W         = 8;
  localparam int QB             = 24;
  localparam int COORD_FRAC_DEF = 16;
  localparam int OUT_FRAC_DEF   = 14;
  localparam int FIFO_DEPTH_DEF = 4;

  // offsets span [-1, 1) in Q24, a gradient sum spans [-2, 2]
  localparam int OFS_W  = QB + 2;
  localparam int GRAD_W = QB + 3;
  localparam int FADE_W = QB + 1;

  localparam int FADE_C3 = 10;
  localparam int FADE_C4 = 15;
  localparam int FADE_C5 = 6;

  // gradient select codes, taken from the two low hash bits
  localparam logic [1:0] GRAD_PP = 2'd0;  //  dx + dy
  localparam logic [1:0] GRAD_NP = 2'd1;  // -dx + dy
  localparam logic [1:0] GRAD_PN = 2'd2;  //  dx - dy
  localparam logic [1:0] GRAD_NN = 2'd3;  // -dx - dy

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  // hashed work word handed from the front end to the arithmetic back end
  typedef struct packed {
    logic [QB-1:0] fx;
    logic [QB-1:0] fy;
    logic [1:0]    h_aa;
    logic [1:0]    h_ab;
    logic [1:0]    h_ba;
    logic [1:0]    h_bb;
  } pnz_work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pnz_fifo_stat_t;

  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

  function automatic logic signed [GRAD_W-1:0] grad_sel(input logic [1:0] sel,
                                                       input logic signed [OFS_W-1:0] dx,
                                                       input logic signed [OFS_W-1:0] dy);
    logic signed [GRAD_W-1:0] ex;
    logic signed [GRAD_W-1:0] ey;
    logic signed [GRAD_W-1:0] res;
    ex = GRAD_W'(dx);
    ey = GRAD_W'(dy);
    unique case (sel)
      GRAD_PP: res = ex + ey;
      GRAD_NP: res = ey - ex;
      GRAD_PN: res = ex - ey;
      GRAD_NN: res = -ex - ey;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: hw/rtl/pnz_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample point in, noise word out.
// Depends on pnz_pkg for field widths.

interface pnz_in_if import pnz_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  x_coord;
  logic signed [COORD_W-1:0]  y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface pnz_out_if import pnz_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [NOISE_W-1:0]  noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

FILE: hw/rtl/pnz_front.sv
`timescale 1ns / 1ps
// Front end: accepts sample points, splits cell and fraction, hashes the four corners.
// Depends on pnz_pkg and pnz_ifs; feeds pnz_fifo.

module pnz_front import pnz_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  pnz_in_if.sink         in_chan,
  input  pnz_fifo_stat_t fifo_stat,
  output logic           push,
  output pnz_work_t      push_word
);

  localparam int FRAC_SH = QB - COORD_FRAC_BITS;

  logic              adv;
  logic              s0_vld_r;
  logic [CELL_W-1:0] s0_cx_r, s0_cy_r;
  logic [QB-1:0]     s0_fx_r, s0_fy_r;
  logic              s1_vld_r;
  logic [CELL_W-1:0] s1_a_r, s1_b_r;
  logic [QB-1:0]     s1_fx_r, s1_fy_r;

  logic [QB-1:0]     fx_nxt, fy_nxt;
  logic [CELL_W-1:0] a_nxt, b_nxt;
  logic [7:0]        h_aa, h_ab, h_ba, h_bb;

  // hold the whole front while the last stage waits on a full queue
  assign adv           = !(s1_vld_r && fifo_stat.full);
  assign in_chan.ready = adv;
  assign push          = s1_vld_r && adv;

  assign fx_nxt = QB'(in_chan.x_coord[COORD_FRAC_BITS-1:0]) << FRAC_SH;
  assign fy_nxt = QB'(in_chan.y_coord[COORD_FRAC_BITS-1:0]) << FRAC_SH;

  assign a_nxt = 8'(perm(s0_cx_r) + s0_cy_r);
  assign b_nxt = 8'(perm(8'(s0_cx_r + 8'd1)) + s0_cy_r);

  assign h_aa = perm(s1_a_r);
  assign h_ab = perm(8'(s1_a_r + 8'd1));
  assign h_ba = perm(s1_b_r);
  assign h_bb = perm(8'(s1_b_r + 8'd1));

  always_comb begin
    push_word.fx   = s1_fx_r;
    push_word.fy   = s1_fy_r;
    push_word.h_aa = h_aa[1:0];
    push_word.h_ab = h_ab[1:0];
    push_word.h_ba = h_ba[1:0];
    push_word.h_bb = h_bb[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_chan.valid;
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cx_r <= in_chan.x_coord[COORD_FRAC_BITS +: CELL_W];
      s0_cy_r <= in_chan.y_coord[COORD_FRAC_BITS +: CELL_W];
      s0_fx_r <= fx_nxt;
      s0_fy_r <= fy_nxt;
      s1_a_r  <= a_nxt;
      s1_b_r  <= b_nxt;
      s1_fx_r <= s0_fx_r;
      s1_fy_r <= s0_fy_r;
    end
  end

endmodule

FILE: hw/rtl/pnz_fifo.sv
`timescale 1ns / 1ps
// Short queue of hashed work words between the front end and the back end.
// Depends on pnz_pkg.

module pnz_fifo import pnz_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pnz_work_t      push_word,
  input  logic           pop,
  output pnz_work_t      pop_word,
  output pnz_fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pnz_work_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_word   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= CNT_W'(cnt_r - 1'b1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: hw/rtl/pnz_back.sv
`timescale 1ns / 1ps
// Back end: fade curves, corner gradients, bilinear blend, rounding and saturation.
// Depends on pnz_pkg and pnz_ifs; drains pnz_fifo.

module pnz_back import pnz_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pnz_fifo_stat_t fifo_stat,
  input  pnz_work_t      pop_word,
  output logic           pop,
  pnz_out_if.source      out_chan
);

  localparam int SH        = QB - OUT_FRAC_BITS;
  localparam int DIFF_W    = GRAD_W + 1;
  localparam int WT_W      = FADE_W + 1;
  localparam int PROD_W    = WT_W + DIFF_W;
  localparam int RND_W     = GRAD_W + 1;
  localparam int FSUM_W    = QB + 4;
  localparam int NSTAGE    = 8;

  localparam logic signed [OFS_W-1:0] Q_ONE    = {2'b01, {QB{1'b0}}};
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (SH - 1);
  localparam logic signed [RND_W-1:0] SAT_HI   = RND_W'((1 << (NOISE_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO   = -RND_W'(1 << (NOISE_W - 1));

  function automatic logic [FADE_W-1:0] fade_clamp(input logic [QB-1:0] t3,
                                                   input logic [QB-1:0] t4,
                                                   input logic [QB-1:0] t5);
    logic [FSUM_W-1:0] pos;
    logic [FSUM_W-1:0] neg;
    logic [FSUM_W-1:0] dif;
    pos = FSUM_W'(FADE_C3) * FSUM_W'(t3) + FSUM_W'(FADE_C5) * FSUM_W'(t5);
    neg = FSUM_W'(FADE_C4) * FSUM_W'(t4);
    dif = pos - neg;
    if (neg >= pos) begin
      return '0;
    end else if (dif > FSUM_W'(1 << QB)) begin
      return FADE_W'(1 << QB);
    end else begin
      return FADE_W'(dif);
    end
  endfunction

  logic                en;
  logic [NSTAGE-1:0]   vld_r;
  logic                out_vld_r;
  logic signed [NOISE_W-1:0] noise_r;

  // stage 1: squares and corner gradients
  logic [QB-1:0]             b1_tx_r, b1_ty_r, b1_t2x_r, b1_t2y_r;
  logic signed [GRAD_W-1:0]  b1_gaa_r, b1_gab_r, b1_gba_r, b1_gbb_r;
  // stages 2..4: powers of t
  logic [QB-1:0]             b2_tx_r, b2_ty_r, b2_t3x_r, b2_t3y_r;
  logic [QB-1:0]             b3_tx_r, b3_ty_r, b3_t3x_r, b3_t3y_r, b3_t4x_r, b3_t4y_r;
  logic [QB-1:0]             b4_t3x_r, b4_t3y_r, b4_t4x_r, b4_t4y_r, b4_t5x_r, b4_t5y_r;
  logic signed [GRAD_W-1:0]  b2_gaa_r, b2_gab_r, b2_gba_r, b2_gbb_r;
  logic signed [GRAD_W-1:0]  b3_gaa_r, b3_gab_r, b3_gba_r, b3_gbb_r;
  logic signed [GRAD_W-1:0]  b4_gaa_r, b4_gab_r, b4_gba_r, b4_gbb_r;
  // stage 5: fade weights
  logic [FADE_W-1:0]         b5_u_r, b5_v_r;
  logic signed [GRAD_W-1:0]  b5_gaa_r, b5_gab_r, b5_gba_r, b5_gbb_r;
  // stage 6: x blend products
  logic signed [PROD_W-1:0]  b6_p1_r, b6_p2_r;
  logic signed [GRAD_W-1:0]  b6_gaa_r, b6_gab_r;
  logic [FADE_W-1:0]         b6_v_r;
  // stage 7: x blend results
  logic signed [GRAD_W-1:0]  b7_q1_r, b7_q2_r;
  logic [FADE_W-1:0]         b7_v_r;
  // stage 8: y blend product
  logic signed [PROD_W-1:0]  b8_p_r;
  logic signed [GRAD_W-1:0]  b8_q1_r;

  logic [2*QB-1:0]           sq_x, sq_y, c_x, c_y, f_x, f_y, g_x, g_y;
  logic signed [OFS_W-1:0]   dx0, dy0, dx1, dy1;
  logic signed [DIFF_W-1:0]  d1, d2, dq;
  logic signed [PROD_W-1:0]  p1_nxt, p2_nxt, p_nxt, p1_sh, p2_sh, p_sh;
  logic signed [GRAD_W-1:0]  q1_nxt, q2_nxt, r_nxt;
  logic signed [RND_W-1:0]   rr, o_full;
  logic signed [NOISE_W-1:0] noise_nxt;

  // advance the whole back end whenever the output register can take a word
  assign en  = !out_vld_r || out_chan.ready;
  assign pop = en && !fifo_stat.empty;

  assign out_chan.valid       = out_vld_r;
  assign out_chan.noise_value = noise_r;

  always_comb begin
    sq_x = (2*QB)'(pop_word.fx) * (2*QB)'(pop_word.fx);
    sq_y = (2*QB)'(pop_word.fy) * (2*QB)'(pop_word.fy);
    dx0  = $signed({2'b00, pop_word.fx});
    dy0  = $signed({2'b00, pop_word.fy});
    dx1  = dx0 - Q_ONE;
    dy1  = dy0 - Q_ONE;
    c_x  = (2*QB)'(b1_t2x_r) * (2*QB)'(b1_tx_r);
    c_y  = (2*QB)'(b1_t2y_r) * (2*QB)'(b1_ty_r);
    f_x  = (2*QB)'(b2_t3x_r) * (2*QB)'(b2_tx_r);
    f_y  = (2*QB)'(b2_t3y_r) * (2*QB)'(b2_ty_r);
    g_x  = (2*QB)'(b3_t4x_r) * (2*QB)'(b3_tx_r);
    g_y  = (2*QB)'(b3_t4y_r) * (2*QB)'(b3_ty_r);
  end

  always_comb begin
    d1     = DIFF_W'(b5_gba_r) - DIFF_W'(b5_gaa_r);
    d2     = DIFF_W'(b5_gbb_r) - DIFF_W'(b5_gab_r);
    p1_nxt = PROD_W'($signed({1'b0, b5_u_r})) * PROD_W'(d1);
    p2_nxt = PROD_W'($signed({1'b0, b5_u_r})) * PROD_W'(d2);
    // arithmetic shift is the floor toward minus infinity
    p1_sh  = b6_p1_r >>> QB;
    p2_sh  = b6_p2_r >>> QB;
    q1_nxt = b6_gaa_r + GRAD_W'(p1_sh);
    q2_nxt = b6_gab_r + GRAD_W'(p2_sh);
    dq     = DIFF_W'(b7_q2_r) - DIFF_W'(b7_q1_r);
    p_nxt  = PROD_W'($signed({1'b0, b7_v_r})) * PROD_W'(dq);
    p_sh   = b8_p_r >>> QB;
    r_nxt  = b8_q1_r + GRAD_W'(p_sh);
    rr     = RND_W'(r_nxt) + RND_HALF;
    o_full = rr >>> SH;
    if (o_full > SAT_HI) begin
      noise_nxt = NOISE_W'(SAT_HI);
    end else if (o_full < SAT_LO) begin
      noise_nxt = NOISE_W'(SAT_LO);
    end else begin
      noise_nxt = NOISE_W'(o_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[NSTAGE-2:0], pop};
      out_vld_r <= vld_r[NSTAGE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_tx_r  <= pop_word.fx;
      b1_ty_r  <= pop_word.fy;
      b1_t2x_r <= sq_x[2*QB-1:QB];
      b1_t2y_r <= sq_y[2*QB-1:QB];
      b1_gaa_r <= grad_sel(pop_word.h_aa, dx0, dy0);
      b1_gba_r <= grad_sel(pop_word.h_ba, dx1, dy0);
      b1_gab_r <= grad_sel(pop_word.h_ab, dx0, dy1);
      b1_gbb_r <= grad_sel(pop_word.h_bb, dx1, dy1);

      b2_tx_r  <= b1_tx_r;
      b2_ty_r  <= b1_ty_r;
      b2_t3x_r <= c_x[2*QB-1:QB];
      b2_t3y_r <= c_y[2*QB-1:QB];
      b2_gaa_r <= b1_gaa_r;
      b2_gab_r <= b1_gab_r;
      b2_gba_r <= b1_gba_r;
      b2_gbb_r <= b1_gbb_r;

      b3_tx_r  <= b2_tx_r;
      b3_ty_r  <= b2_ty_r;
      b3_t3x_r <= b2_t3x_r;
      b3_t3y_r <= b2_t3y_r;
      b3_t4x_r <= f_x[2*QB-1:QB];
      b3_t4y_r <= f_y[2*QB-1:QB];
      b3_gaa_r <= b2_gaa_r;
      b3_gab_r <= b2_gab_r;
      b3_gba_r <= b2_gba_r;
      b3_gbb_r <= b2_gbb_r;

      b4_t3x_r <= b3_t3x_r;
      b4_t3y_r <= b3_t3y_r;
      b4_t4x_r <= b3_t4x_r;
      b4_t4y_r <= b3_t4y_r;
      b4_t5x_r <= g_x[2*QB-1:QB];
      b4_t5y_r <= g_y[2*QB-1:QB];
      b4_gaa_r <= b3_gaa_r;
      b4_gab_r <= b3_gab_r;
      b4_gba_r <= b3_gba_r;
      b4_gbb_r <= b3_gbb_r;

      b5_u_r   <= fade_clamp(b4_t3x_r, b4_t4x_r, b4_t5x_r);
      b5_v_r   <= fade_clamp(b4_t3y_r, b4_t4y_r, b4_t5y_r);
      b5_gaa_r <= b4_gaa_r;
      b5_gab_r <= b4_gab_r;
      b5_gba_r <= b4_gba_r;
      b5_gbb_r <= b4_gbb_r;

      b6_p1_r  <= p1_nxt;
      b6_p2_r  <= p2_nxt;
      b6_gaa_r <= b5_gaa_r;
      b6_gab_r <= b5_gab_r;
      b6_v_r   <= b5_v_r;

      b7_q1_r  <= q1_nxt;
      b7_q2_r  <= q2_nxt;
      b7_v_r   <= b6_v_r;

      b8_p_r   <= p_nxt;
      b8_q1_r  <= b7_q1_r;

      noise_r  <= noise_nxt;
    end
  end

endmodule

FILE: hw/rtl/perlin_noise_2d_fixed.sv
`timescale 1ns / 1ps
// 2-D gradient noise, fixed point. A sample passes 2 front stages, the queue, and 8 back
// stages followed by the output register.
// Throughput: one sample per cycle; the front and back stall independently through a
// 4-word queue, and the back end is paced only by the output register's ready.
// Reset (synchronous, active low) clears valid bits and queue pointers; no clearing pass.

module perlin_noise_2d_fixed import pnz_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_DEF,
  parameter int FIFO_DEPTH      = FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pnz_in_if.sink    in_chan,
  pnz_out_if.source out_chan
);

  logic           push;
  logic           pop;
  pnz_work_t      push_word;
  pnz_work_t      pop_word;
  pnz_fifo_stat_t fifo_stat;

  pnz_front #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_word (push_word)
  );

  pnz_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .stat      (fifo_stat)
  );

  pnz_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .pop_word  (pop_word),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule

FILE: bench/tb_perlin_noise_2d_fixed.sv
`timescale 1ns / 1ps
// Self-checking bench for perlin_noise_2d_fixed: random and directed sample points in,
// noise words checked against a built-in fixed-point predictor.
// Depends on pnz_pkg, the pnz_in_if / pnz_out_if channel interfaces and the block itself.

module tb_perlin_noise_2d_fixed;
  import pnz_pkg::*;

  localparam int  COORD_FRAC     = COORD_FRAC_DEF;
  localparam int  OUT_FRAC       = OUT_FRAC_DEF;
  localparam int  LATENCY        = 11;
  localparam int  RANDOM_POINTS  = 900;
  localparam int  LONG_HOLD      = 300;
  localparam int  HOLD_AFTER     = 250;
  localparam int  WATCHDOG_LIMIT = 2000;
  localparam longint QONE        = longint'(1) << QB;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    bit                        drain_first;
  } sample_pt_t;

  logic clk;
  logic rst_n;

  pnz_in_if  in_bus();
  pnz_out_if out_bus();

  perlin_noise_2d_fixed #(
    .COORD_FRAC_BITS(COORD_FRAC),
    .OUT_FRAC_BITS  (OUT_FRAC)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  sample_pt_t              pending_points[$];
  logic signed [NOISE_W-1:0] expected_noise[$];

  int sent_count      = 0;
  int checked_count   = 0;
  int mismatch_count  = 0;
  int directed_count  = 0;
  int gap_left        = 0;
  int stall_left      = 0;
  int hold_left       = 0;
  bit long_hold_done  = 0;
  int idle_cycles     = 0;

  // start low so the first rising edge comes after reset is applied
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint fade_q24(longint t);
    longint unsigned ut, t2, t3, t4, t5;
    longint f;
    ut = t;
    t2 = (ut * ut) >> QB;
    t3 = (t2 * ut) >> QB;
    t4 = (t3 * ut) >> QB;
    t5 = (t4 * ut) >> QB;
    f = FADE_C3 * longint'(t3) - FADE_C4 * longint'(t4) + FADE_C5 * longint'(t5);
    if (f < 0) f = 0;
    if (f > QONE) f = QONE;
    return f;
  endfunction

  function automatic longint corner_grad(logic [1:0] h, longint dx, longint dy);
    longint g;
    case (h)
      GRAD_PP: g = dx + dy;
      GRAD_NP: g = -dx + dy;
      GRAD_PN: g = dx - dy;
      default: g = -dx - dy;
    endcase
    return g;
  endfunction

  // >>> on a signed longint floors toward minus infinity
  function automatic longint blend(longint w, longint a, longint b);
    return a + ((w * (b - a)) >>> QB);
  endfunction

  function automatic logic signed [NOISE_W-1:0] noise_at(logic signed [COORD_W-1:0] xc,
                                                         logic signed [COORD_W-1:0] yc);
    logic [7:0] cx, cy, cx1, a, b, a1, b1;
    logic [7:0] haa, hab, hba, hbb;
    longint fx, fy, u, v, q1, q2, r, o;
    cx  = xc[COORD_FRAC +: CELL_W];
    cy  = yc[COORD_FRAC +: CELL_W];
    fx  = longint'(xc[COORD_FRAC-1:0]) << (QB - COORD_FRAC);
    fy  = longint'(yc[COORD_FRAC-1:0]) << (QB - COORD_FRAC);
    u   = fade_q24(fx);
    v   = fade_q24(fy);
    cx1 = cx + 8'd1;
    a   = PERM_ROM[cx] + cy;
    b   = PERM_ROM[cx1] + cy;
    a1  = a + 8'd1;
    b1  = b + 8'd1;
    haa = PERM_ROM[a];
    hab = PERM_ROM[a1];
    hba = PERM_ROM[b];
    hbb = PERM_ROM[b1];
    q1  = blend(u, corner_grad(haa[1:0], fx, fy), corner_grad(hba[1:0], fx - QONE, fy));
    q2  = blend(u, corner_grad(hab[1:0], fx, fy - QONE),
                corner_grad(hbb[1:0], fx - QONE, fy - QONE));
    r   = blend(v, q1, q2);
    o   = (r + (longint'(1) << (QB - OUT_FRAC - 1))) >>> (QB - OUT_FRAC);
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return NOISE_W'(o);
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [15:0] frac_extreme();
    logic [15:0] f;
    case ($urandom_range(0, 5))
      0:       f = 16'h0000;
      1:       f = 16'h0001;
      2:       f = 16'h7FFF;
      3:       f = 16'h8000;
      4:       f = 16'hFFFE;
      default: f = 16'hFFFF;
    endcase
    return f;
  endfunction

  function automatic sample_pt_t rand_point();
    sample_pt_t p;
    int unsigned kind;
    logic [31:0] hx, hy;
    kind = $urandom_range(0, 99);
    p.drain_first = 1'b0;
    if (kind < 50) begin
      p.x = $urandom;
      p.y = $urandom;
    end else if (kind < 85) begin
      // stay within a few cells of the origin, both signs
      p.x = int'($urandom_range(0, 32 * 65536)) - 16 * 65536;
      p.y = int'($urandom_range(0, 32 * 65536)) - 16 * 65536;
    end else begin
      hx = $urandom;
      hy = $urandom;
      p.x = {hx[31:16], frac_extreme()};
      p.y = {hy[31:16], frac_extreme()};
    end
    return p;
  endfunction

  function automatic int pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y);
    sample_pt_t p;
    p.x = x;
    p.y = y;
    p.drain_first = 1'b0;
    pending_points.push_back(p);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    sample_pt_t p;
    bit fire;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      fire = in_bus.valid && in_bus.ready;
      if (fire) begin
        expected_noise.push_back(noise_at(in_bus.x_coord, in_bus.y_coord));
        sent_count++;
      end
      if (!in_bus.valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_points.size() != 0 && pending_points[0].drain_first &&
                     expected_noise.size() != 0) begin
          // hold until every outstanding noise word has come back
          in_bus.valid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          p = pending_points.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.x_coord <= p.x;
          in_bus.y_coord <= p.y;
          gap_left = pick_gap(((sent_count / 64) % 4) == 3);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    logic signed [NOISE_W-1:0] want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_noise.size() == 0) begin
          $error("noise_value: unexpected word %0d with nothing outstanding",
                 out_bus.noise_value);
          mismatch_count++;
        end else begin
          want = expected_noise.pop_front();
          if (out_bus.noise_value !== want) begin
            $error("noise_value mismatch: expected %0d, actual %0d", want,
                   out_bus.noise_value);
            mismatch_count++;
          end
          checked_count++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (!long_hold_done && checked_count >= HOLD_AFTER) begin
        // long back-pressure: let the block fill up and stall its input
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (((checked_count / 64) % 4) == 1 || $urandom_range(0, 99) < 70) begin
        out_bus.ready <= 1'b1;
      end else begin
        stall_left = pick_gap(1'b0);
        out_bus.ready <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_perlin_noise_2d_fixed NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    sample_pt_t p;
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.x_coord = '0;
    in_bus.y_coord = '0;
    out_bus.ready  = 1'b0;

    // directed: origin, coordinate extremes, cell wrap, fraction edges
    add_point(32'h0000_0000, 32'h0000_0000);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h8000_0000);
    add_point(32'h7FFF_FFFF, 32'h8000_0000);
    add_point(32'h8000_0000, 32'h7FFF_FFFF);
    add_point(32'hFFFF_FFFF, 32'h0000_0000);
    add_point(32'h00FF_FFFF, 32'h00FF_8000);
    add_point(32'h0100_0000, 32'h0100_0001);
    add_point(32'h0000_8000, 32'h0000_8000);
    add_point(32'hFFFF_0000, 32'hFFFF_0000);
    add_point(32'h0000_0001, 32'h0000_0001);
    // walk a few cells so every gradient choice shows up
    for (int i = 0; i < 8; i++)
      add_point({8'h00, 8'(i), 16'h4000}, {8'h00, 8'(7 - i), 16'hC000});
    directed_count = pending_points.size();

    for (int i = 0; i < RANDOM_POINTS; i++) begin
      p = rand_point();
      // drain fully before the random part and once in the middle of it
      p.drain_first = (i == 0) || (i == RANDOM_POINTS / 2);
      pending_points.push_back(p);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_points.size() != 0 || in_bus.valid || expected_noise.size() != 0);
    repeat (4 * LATENCY) @(posedge clk);

    $display("sent %0d sample points (%0d directed, %0d random), checked %0d noise words",
             sent_count, directed_count, sent_count - directed_count, checked_count);
    $display("included a %0d-cycle receiver hold-off and two full drains of the pipeline",
             LONG_HOLD);
    if (mismatch_count == 0 && expected_noise.size() == 0) begin
      $display("tb_perlin_noise_2d_fixed OK");
    end else begin
      $display("tb_perlin_noise_2d_fixed NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pnz_pkg.sv
hw/rtl/pnz_ifs.sv
hw/rtl/pnz_front.sv
hw/rtl/pnz_fifo.sv
hw/rtl/pnz_back.sv
hw/rtl/perlin_noise_2d_fixed.sv
bench/tb_perlin_noise_2d_fixed.sv
